[src/hrpr_pkg.sv]
// Shared types and constants for the hopping rc packet receiver.
// Used by every module under src; depends on nothing.
package hrpr_pkg;

	// configuration register indexes and widths
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 22;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BOUND_TX_ID      = 3'd0,
		REG_MAX_MISSED       = 3'd1,
		REG_HUNT_DWELL       = 3'd2,
		REG_WAIT_FIRST_HALF  = 3'd3,
		REG_WAIT_SECOND_HALF = 3'd4,
		REG_MISSED_STEP      = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic [15:0] RstBoundTxId     = 16'd0;
	localparam logic [15:0] RstMaxMissed     = 16'd100;
	localparam logic [21:0] RstHuntDwell     = 22'd500000;
	localparam logic [15:0] RstWaitFirstHalf = 16'd3500;
	localparam logic [15:0] RstWaitSecondHalf = 16'd500;
	localparam logic [15:0] RstMissedStep    = 16'd6800;

	// stream widths
	localparam int unsigned InDataW  = 160;
	localparam int unsigned OutDataW = 80;

	// packet constants
	localparam logic [7:0] PktHeader = 8'h81;

	// input commands
	localparam logic [1:0] CmdPoll    = 2'd0;
	localparam logic [1:0] CmdPacket  = 2'd1;
	localparam logic [1:0] CmdRestart = 2'd2;

	// result status codes
	localparam logic [1:0] StatNone     = 2'd0;
	localparam logic [1:0] StatSticks   = 2'd1;
	localparam logic [1:0] StatFailsafe = 2'd2;

	typedef struct packed {
		logic [15:0] bound_tx_id;
		logic [15:0] max_missed_frames;
		logic [21:0] hunt_dwell_us;
		logic [15:0] wait_after_first_half_us;
		logic [15:0] wait_after_second_half_us;
		logic [15:0] missed_slot_step_us;
	} cfg_t;

	// item class decided by the front end
	typedef enum logic [1:0] {
		KIND_POLL    = 2'd0,
		KIND_PACKET  = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_REJECT  = 2'd3
	} kind_t;

	// classified item handed to the back end
	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_us;
		logic [4:0]  pkt_hop;
		logic [4:0]  new_code;
		logic        second_half;
		logic        failsafe;
		logic [11:0] stick_a;
		logic [11:0] stick_b;
		logic [11:0] stick_c;
		logic [11:0] stick_d;
		logic [7:0]  rssi;
	} item_t;

endpackage

[src/hopping_rc_packet_receiver_top.sv]
// Hopping rc packet receiver, top level.
// An input transaction is registered in the queue, then its result in the back end result register.
// Throughput: one transaction per cycle unless m_tready stalls, set by the link state update.
// A two-entry queue parts the classifying front end from the state back end.
// Reset: link idle, hop, code, deadline and counters zero, registers at defaults.
// Depends on hrpr_pkg, hrpr_cfg, hrpr_front, hrpr_queue, hrpr_back.
module hopping_rc_packet_receiver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [hrpr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hrpr_pkg::CfgDataW-1:0] cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cmd[1:0], now_us[33:2], packet_head[97:34], packet_tail[153:98], zero fill
	input  logic [hrpr_pkg::InDataW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], retune[2], in_sync[3], hop_channel[8:4], radio_channel[16:9],
	// channel_group[17], stick_a[29:18], stick_b[41:30], stick_c[53:42],
	// stick_d[65:54], signal_strength_raw[73:66], zero fill
	output logic [hrpr_pkg::OutDataW-1:0] m_tdata
);
	import hrpr_pkg::*;

	cfg_t  cfg;
	item_t front_item;
	item_t queue_item;
	logic  queue_full;
	logic  queue_valid;
	logic  back_take;

	hrpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hrpr_front u_front (
		.in_data     (s_tdata),
		.bound_tx_id (cfg.bound_tx_id),
		.item        (front_item)
	);

	assign s_tready = !queue_full;

	hrpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (s_tvalid && !queue_full),
		.wr_item  (front_item),
		.full     (queue_full),
		.rd_en    (back_take),
		.rd_valid (queue_valid),
		.rd_item  (queue_item)
	);

	hrpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (queue_valid),
		.item       (queue_item),
		.item_take  (back_take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule

[src/hrpr_cfg.sv]
// Configuration register bank of the receiver.
// Depends on hrpr_pkg.
module hrpr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [hrpr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hrpr_pkg::CfgDataW-1:0] cfg_wdata,
	output hrpr_pkg::cfg_t                cfg
);
	import hrpr_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bound_tx_id               <= RstBoundTxId;
			cfg_q.max_missed_frames         <= RstMaxMissed;
			cfg_q.hunt_dwell_us             <= RstHuntDwell;
			cfg_q.wait_after_first_half_us  <= RstWaitFirstHalf;
			cfg_q.wait_after_second_half_us <= RstWaitSecondHalf;
			cfg_q.missed_slot_step_us       <= RstMissedStep;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_BOUND_TX_ID:      cfg_q.bound_tx_id <= cfg_wdata[15:0];
				REG_MAX_MISSED:       cfg_q.max_missed_frames <= cfg_wdata[15:0];
				REG_HUNT_DWELL:       cfg_q.hunt_dwell_us <= cfg_wdata;
				REG_WAIT_FIRST_HALF:  cfg_q.wait_after_first_half_us <= cfg_wdata[15:0];
				REG_WAIT_SECOND_HALF: cfg_q.wait_after_second_half_us <= cfg_wdata[15:0];
				REG_MISSED_STEP:      cfg_q.missed_slot_step_us <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/hrpr_front.sv]
// Front end: unpacks an input transaction and classifies it.
// Checks crc bit, header and transmitter id; extracts hop code and sticks. Depends on hrpr_pkg.
module hrpr_front (
	input  logic [hrpr_pkg::InDataW-1:0] in_data,
	input  logic [15:0]                  bound_tx_id,
	output hrpr_pkg::item_t              item
);
	import hrpr_pkg::*;

	logic [1:0]  cmd;
	logic [63:0] head;
	logic [55:0] tail;
	logic [7:0]  b0, b1, b2, b5, b6, b7, b8, b9, b10, b11, b12, b13, b14;
	logic        pkt_ok;

	// field and byte extraction
	always_comb begin
		cmd  = in_data[1:0];
		head = in_data[97:34];
		tail = in_data[153:98];
		b0   = head[63:56];
		b1   = head[55:48];
		b2   = head[47:40];
		b5   = head[23:16];
		b6   = head[15:8];
		b7   = head[7:0];
		b8   = tail[55:48];
		b9   = tail[47:40];
		b10  = tail[39:32];
		b11  = tail[31:24];
		b12  = tail[23:16];
		b13  = tail[15:8];
		b14  = tail[7:0];
	end

	// packet checks that do not depend on link state
	assign pkt_ok = b14[7] && (b0 == PktHeader) &&
		(b1 == bound_tx_id[15:8]) && (b2 == bound_tx_id[7:0]);

	// classification and payload
	always_comb begin
		case (cmd)
			CmdRestart: item.kind = KIND_RESTART;
			CmdPacket:  item.kind = pkt_ok ? KIND_PACKET : KIND_REJECT;
			default:    item.kind = KIND_POLL;
		endcase
		item.now_us      = in_data[33:2];
		item.pkt_hop     = b5[7:3];
		item.new_code    = {b11[2:0], b12[7:6]};
		item.second_half = b12[3];
		item.failsafe    = b12[2];
		item.stick_a     = {b5[2:0], b6, b7[7]};
		item.stick_b     = {b7[6:0], b8[7:3]};
		item.stick_c     = {b8[2:0], b9, b10[7]};
		item.stick_d     = {b10[6:0], b11[7:3]};
		item.rssi        = b13;
	end

endmodule

[src/hrpr_queue.sv]
// Two-entry queue between the front and back ends.
// Holds classified items; depends on hrpr_pkg.
module hrpr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  hrpr_pkg::item_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output hrpr_pkg::item_t rd_item
);
	import hrpr_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full     = count_q[1];
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];

endmodule

[src/hrpr_back.sv]
// Back end: link state machine, hopping, deadlines and the result register.
// Depends on hrpr_pkg.
module hrpr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hrpr_pkg::cfg_t                cfg,
	input  logic                          item_valid,
	input  hrpr_pkg::item_t               item,
	output logic                          item_take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hrpr_pkg::OutDataW-1:0] out_data
);
	import hrpr_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_HUNT = 2'd1,
		MODE_SYNC = 2'd2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [4:0]  hop_q, hop_d;
	logic [4:0]  code_q, code_d;
	logic [31:0] deadline_q, deadline_d;
	logic [16:0] missed_q, missed_d;
	logic [1:0]  halves_q, halves_d;
	logic        valid_q;
	logic [OutDataW-1:0] data_q, data_d;

	logic [31:0] since;
	logic        passed;
	logic [4:0]  hop_step;
	logic [16:0] missed_inc;
	logic [1:0]  status;
	logic        retune, group;
	logic [11:0] sa, sb, sc, sd;
	logic [7:0]  rssi, radio;

	// next hop from the current hop and code, wrapping above 29
	function automatic logic [4:0] next_hop(logic [4:0] hop, logic [4:0] code);
		logic [6:0] ch;
		ch = {2'b00, hop} + {2'b00, code} + 7'd2;
		if (ch > 7'd29) begin
			ch = ch - 7'd31;
		end
		return ch[4:0];
	endfunction

	assign item_take = item_valid && (!valid_q || out_ready);

	// deadline compare with signed wrap
	assign since      = item.now_us - deadline_q;
	assign passed     = (since != 32'd0) && !since[31];
	assign hop_step   = next_hop(hop_q, code_q);
	assign missed_inc = (missed_q != 17'h1FFFF) ? missed_q + 17'd1 : missed_q;

	// state update for one item
	always_comb begin
		mode_d     = mode_q;
		hop_d      = hop_q;
		code_d     = code_q;
		deadline_d = deadline_q;
		missed_d   = missed_q;
		halves_d   = halves_q;
		status     = StatNone;
		retune     = 1'b0;
		group      = 1'b0;
		rssi       = 8'd0;
		sa         = 12'd0;
		sb         = 12'd0;
		sc         = 12'd0;
		sd         = 12'd0;
		if (item.kind == KIND_RESTART) begin
			mode_d     = MODE_HUNT;
			hop_d      = hop_step;
			retune     = 1'b1;
			deadline_d = item.now_us + {10'd0, cfg.hunt_dwell_us};
		end else if (mode_q == MODE_HUNT || mode_q == MODE_SYNC) begin
			if (item.kind == KIND_PACKET) begin
				if (item.pkt_hop == hop_q) begin
					code_d = item.new_code;
					if (mode_q == MODE_HUNT) begin
						if (item.second_half) begin
							missed_d   = 17'd0;
							halves_d   = 2'b11;
							mode_d     = MODE_SYNC;
							deadline_d = item.now_us +
								{16'd0, cfg.wait_after_second_half_us};
						end
					end else begin
						missed_d = 17'd0;
						if (item.second_half) begin
							deadline_d = item.now_us +
								{16'd0, cfg.wait_after_second_half_us};
							halves_d = halves_q | 2'b10;
							group    = 1'b1;
						end else begin
							deadline_d = item.now_us +
								{16'd0, cfg.wait_after_first_half_us};
							halves_d = halves_q | 2'b01;
						end
						rssi = item.rssi;
						if (item.failsafe) begin
							status = StatFailsafe;
						end else begin
							status = StatSticks;
							sa     = item.stick_a;
							sb     = item.stick_b;
							sc     = item.stick_c;
							sd     = item.stick_d;
						end
					end
				end
			end else if (item.kind == KIND_POLL && passed) begin
				hop_d  = hop_step;
				retune = 1'b1;
				if (mode_q == MODE_HUNT) begin
					deadline_d = deadline_q + {10'd0, cfg.hunt_dwell_us};
				end else begin
					deadline_d = deadline_q + {16'd0, cfg.missed_slot_step_us};
					halves_d   = 2'b00;
					if (halves_q == 2'b00) begin
						missed_d = missed_inc;
						if (missed_inc > {1'b0, cfg.max_missed_frames}) begin
							// too many empty slots: back to hunting
							mode_d     = MODE_HUNT;
							deadline_d = item.now_us + {10'd0, cfg.hunt_dwell_us};
							halves_d   = halves_q;
						end
					end
				end
			end
		end
		radio  = {hop_d, 3'b000} - {2'b00, hop_d, 1'b0} + 8'd16;
		data_d = {6'd0, rssi, sd, sc, sb, sa, group, radio, hop_d,
			(mode_d == MODE_SYNC), retune, status};
	end

	// link state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			hop_q      <= 5'd0;
			code_q     <= 5'd0;
			deadline_q <= 32'd0;
			missed_q   <= 17'd0;
			halves_q   <= 2'b00;
			valid_q    <= 1'b0;
			data_q     <= '0;
		end else begin
			if (item_take) begin
				mode_q     <= mode_d;
				hop_q      <= hop_d;
				code_q     <= code_d;
				deadline_q <= deadline_d;
				missed_q   <= missed_d;
				halves_q   <= halves_d;
				data_q     <= data_d;
				valid_q    <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[sim/hopping_rc_packet_receiver_top_tb.sv]
// Self-checking testbench for hopping_rc_packet_receiver_top: drives polls, packets and
// restarts over the stream ports and checks each result against a built-in link predictor.
// Depends on hrpr_pkg and the RTL under src; needs no files or arguments.
module hopping_rc_packet_receiver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hrpr_pkg::*;

	localparam logic [1:0] CmdSpare = 2'd3;
	localparam int QuietLimit = 5000;
	localparam int ItemsPerPhase = 100;

	typedef enum logic [1:0] {
		LINK_IDLE = 2'd0,
		LINK_HUNT = 2'd1,
		LINK_SYNC = 2'd2
	} link_mode_e;

	typedef enum int {
		DEF_NONE,
		DEF_CRC,
		DEF_HEADER,
		DEF_HOP,
		DEF_ID_HI,
		DEF_ID_LO
	} pkt_defect_e;

	// one result transaction, highest field first so it overlays m_tdata[73:0]
	typedef struct packed {
		logic [7:0]  rssi;
		logic [11:0] stick_d;
		logic [11:0] stick_c;
		logic [11:0] stick_b;
		logic [11:0] stick_a;
		logic        chan_group;
		logic [7:0]  radio;
		logic [4:0]  hop;
		logic        in_sync;
		logic        retune;
		logic [1:0]  status;
	} link_report_t;

	// link state predictor plus the queue of reports still awaited from the block
	class hop_receiver_scoreboard;
		logic [15:0] tx_id;
		logic [15:0] max_missed;
		logic [21:0] dwell_us;
		logic [15:0] first_wait_us;
		logic [15:0] second_wait_us;
		logic [15:0] step_us;
		link_mode_e  mode;
		logic [4:0]  hop;
		logic [4:0]  code;
		logic [31:0] deadline;
		logic [16:0] missed;
		logic [1:0]  halves;
		link_report_t awaited_reports[$];
		int errors;

		function new();
			tx_id = RstBoundTxId;
			max_missed = RstMaxMissed;
			dwell_us = RstHuntDwell;
			first_wait_us = RstWaitFirstHalf;
			second_wait_us = RstWaitSecondHalf;
			step_us = RstMissedStep;
			mode = LINK_IDLE;
			hop = '0;
			code = '0;
			deadline = '0;
			missed = '0;
			halves = '0;
			errors = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [21:0] value);
			case (idx)
				REG_BOUND_TX_ID:      tx_id = value[15:0];
				REG_MAX_MISSED:       max_missed = value[15:0];
				REG_HUNT_DWELL:       dwell_us = value;
				REG_WAIT_FIRST_HALF:  first_wait_us = value[15:0];
				REG_WAIT_SECOND_HALF: second_wait_us = value[15:0];
				REG_MISSED_STEP:      step_us = value[15:0];
				default: ;
			endcase
		endfunction

		// hop by code plus two, folding values above 29 back by 31
		function void advance_hop();
			int unsigned next_ch;
			next_ch = hop + code + 2;
			if (next_ch > 29)
				next_ch -= 31;
			hop = next_ch[4:0];
		endfunction

		// signed wrap compare against the slot deadline
		function bit slot_expired(logic [31:0] now);
			logic [31:0] gap;
			gap = now - deadline;
			return (gap != 0) && !gap[31];
		endfunction

		// predict the report for one accepted input transaction
		function void take_item(logic [1:0] cmd, logic [31:0] now, logic [63:0] head,
				logic [55:0] tail);
			logic [7:0] b[15];
			link_report_t r;
			logic ok;
			logic [3:0] nib;
			logic fell_back;
			r = '0;
			for (int i = 0; i < 8; i++)
				b[i] = head[63 - 8 * i -: 8];
			for (int i = 0; i < 7; i++)
				b[8 + i] = tail[55 - 8 * i -: 8];

			if (cmd == CmdRestart) begin
				mode = LINK_HUNT;
				advance_hop();
				r.retune = 1'b1;
				deadline = now + dwell_us;
			end else if (mode != LINK_IDLE) begin
				if (cmd == CmdPacket) begin
					ok = b[14][7] && (b[0] == PktHeader) && (b[5][7:3] == hop) &&
						(b[1] == tx_id[15:8]) && (b[2] == tx_id[7:0]);
					if (ok) begin
						nib = b[12][3:0];
						code = {b[11][2:0], b[12][7:6]};
						if (mode == LINK_HUNT) begin
							// only a channels 5..8 packet locks on
							if (nib[3]) begin
								missed = '0;
								halves = 2'd3;
								mode = LINK_SYNC;
								deadline = now + second_wait_us;
							end
						end else begin
							missed = '0;
							if (nib[3]) begin
								deadline = now + second_wait_us;
								halves |= 2'd2;
								r.chan_group = 1'b1;
							end else begin
								deadline = now + first_wait_us;
								halves |= 2'd1;
							end
							r.rssi = b[13];
							if (nib[2]) begin
								r.status = StatFailsafe;
							end else begin
								r.status = StatSticks;
								r.stick_a = {b[5][2:0], b[6], b[7][7]};
								r.stick_b = {b[7][6:0], b[8][7:3]};
								r.stick_c = {b[8][2:0], b[9], b[10][7]};
								r.stick_d = {b[10][6:0], b[11][7:3]};
							end
						end
					end
				end else if (slot_expired(now)) begin
					if (mode == LINK_HUNT) begin
						advance_hop();
						r.retune = 1'b1;
						deadline += dwell_us;
					end else begin
						fell_back = 1'b0;
						deadline += step_us;
						// empty slot: count it and drop to hunt past the limit
						if (halves == 2'd0) begin
							if (missed != 17'h1FFFF)
								missed++;
							if (missed > max_missed) begin
								mode = LINK_HUNT;
								advance_hop();
								r.retune = 1'b1;
								deadline = now + dwell_us;
								fell_back = 1'b1;
							end
						end
						if (!fell_back) begin
							halves = 2'd0;
							advance_hop();
							r.retune = 1'b1;
						end
					end
				end
			end

			r.in_sync = (mode == LINK_SYNC);
			r.hop = hop;
			r.radio = {3'd0, hop} * 8'd6 + 8'd16;
			awaited_reports.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		// compare one result transaction with the oldest prediction
		function void check_report(logic [OutDataW-1:0] data);
			link_report_t want;
			link_report_t got;
			if (awaited_reports.size() == 0) begin
				$error("result transaction with nothing expected: %h", data);
				errors++;
				return;
			end
			want = awaited_reports.pop_front();
			got = data[73:0];
			check_field("status", want.status, got.status);
			check_field("retune", want.retune, got.retune);
			check_field("in_sync", want.in_sync, got.in_sync);
			check_field("hop_channel", want.hop, got.hop);
			check_field("radio_channel", want.radio, got.radio);
			check_field("channel_group", want.chan_group, got.chan_group);
			check_field("stick_a", want.stick_a, got.stick_a);
			check_field("stick_b", want.stick_b, got.stick_b);
			check_field("stick_c", want.stick_c, got.stick_c);
			check_field("stick_d", want.stick_d, got.stick_d);
			check_field("signal_strength_raw", want.rssi, got.rssi);
			check_field("zero fill", 32'd0, data[OutDataW-1:74]);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_BOUND_TX_ID;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	hop_receiver_scoreboard link_sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;
	logic [31:0] clock_us = '0;

	hopping_rc_packet_receiver_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, result checking and the stall watchdog
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
		if (m_tvalid && m_tready)
			link_sb.check_report(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("hopping_rc_packet_receiver_top test failed");
			$finish;
		end
	end

	// packet aimed at the given hop and id, optionally broken in one check
	function automatic logic [119:0] make_packet(logic [4:0] hop, logic [15:0] id,
			logic [4:0] code, logic [3:0] nib, pkt_defect_e defect);
		logic [63:0] head;
		logic [63:0] raw;
		logic [55:0] tail;
		logic [31:0] flip;
		head = {$urandom, $urandom};
		raw = {$urandom, $urandom};
		tail = raw[55:0];
		flip = $urandom_range(255, 1);
		head[63:56] = PktHeader;
		head[55:40] = id;
		head[23:19] = hop;
		tail[26:24] = code[4:2];
		tail[23:22] = code[1:0];
		tail[19:16] = nib;
		tail[7] = 1'b1;
		case (defect)
			DEF_CRC:    tail[7] = 1'b0;
			DEF_HEADER: head[63:56] = PktHeader ^ flip[7:0];
			DEF_HOP:    head[23:19] = hop ^ (flip[4:0] | 5'd1);
			DEF_ID_HI:  head[55:48] = head[55:48] ^ flip[7:0];
			DEF_ID_LO:  head[47:40] = head[47:40] ^ flip[7:0];
			default: ;
		endcase
		return {head, tail};
	endfunction

	// one input transaction, with an optional random gap before it
	task automatic send_item(logic [1:0] cmd, logic [31:0] now, logic [119:0] pkt);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, pkt[55:0], pkt[119:56], now, cmd};
		do @(posedge clk); while (!s_tready);
		link_sb.take_item(cmd, now, pkt[119:56], pkt[55:0]);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [21:0] value);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		link_sb.set_register(idx, value);
	endtask

	initial begin
		logic [21:0] tx_v, miss_v, dwell_v, first_v, second_v, step_v;
		logic [31:0] rnd;
		logic [127:0] raw;
		logic [119:0] noise_pkt;
		logic [4:0] code;
		logic [3:0] nib;
		logic [1:0] poll_cmd;
		int pick;
		int items;
		int burst;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 6; phase++) begin
			// receiver-heavy gaps, then sender-heavy, then none
			if (phase < 2) begin
				send_idle = 23;
				recv_idle = 52;
			end else if (phase < 4) begin
				send_idle = 52;
				recv_idle = 23;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end

			// register settings: defaults-like, all minimum, all maximum, then random
			case (phase)
				0: begin
					rnd = $urandom;
					tx_v = {6'd0, rnd[15:0]};
					miss_v = 22'd2;
					dwell_v = 22'd500000;
					first_v = 22'd3500;
					second_v = 22'd500;
					step_v = 22'd6800;
				end
				1: begin
					tx_v = 22'd0;
					miss_v = 22'd1;
					dwell_v = 22'd1;
					first_v = 22'd1;
					second_v = 22'd1;
					step_v = 22'd1;
				end
				2: begin
					tx_v = 22'hFFFF;
					miss_v = 22'hFFFF;
					dwell_v = 22'h3FFFFF;
					first_v = 22'hFFFF;
					second_v = 22'hFFFF;
					step_v = 22'hFFFF;
				end
				default: begin
					rnd = $urandom;
					tx_v = {6'd0, rnd[15:0]};
					rnd = $urandom_range(4, 1);
					miss_v = rnd[21:0];
					rnd = $urandom_range(32'h3FFFFF, 1);
					dwell_v = rnd[21:0];
					rnd = $urandom_range(65535, 1);
					first_v = rnd[21:0];
					rnd = $urandom_range(65535, 1);
					second_v = rnd[21:0];
					rnd = $urandom_range(65535, 1);
					step_v = rnd[21:0];
				end
			endcase
			cfg_write(REG_BOUND_TX_ID, tx_v);
			cfg_write(REG_MAX_MISSED, miss_v);
			cfg_write(REG_HUNT_DWELL, dwell_v);
			cfg_write(REG_WAIT_FIRST_HALF, first_v);
			cfg_write(REG_WAIT_SECOND_HALF, second_v);
			cfg_write(REG_MISSED_STEP, step_v);
			cfg_wen <= 1'b0;

			if (phase == 0) begin
				// idle link ignores everything but a restart
				send_item(CmdPoll, 32'd0, '0);
				send_item(CmdPacket, 32'hFFFF_FFFF, '1);
				send_item(CmdSpare, 32'h1234_5678,
					make_packet(link_sb.hop, link_sb.tx_id, 5'd3, 4'h8, DEF_NONE));
				// restart near the top of time so the deadline wraps
				clock_us = 32'hFFFF_FF00;
				send_item(CmdRestart, clock_us, '0);
				send_item(CmdPoll, link_sb.deadline, '0);
				send_item(CmdPoll, link_sb.deadline + 32'd1, '0);
				clock_us = link_sb.deadline;
				// each acceptance check failing alone
				send_item(CmdPacket, clock_us,
					make_packet(link_sb.hop, link_sb.tx_id, 5'd7, 4'h8, DEF_CRC));
				send_item(CmdPacket, clock_us,
					make_packet(link_sb.hop, link_sb.tx_id, 5'd7, 4'h8, DEF_HEADER));
				send_item(CmdPacket, clock_us,
					make_packet(link_sb.hop, link_sb.tx_id, 5'd7, 4'h8, DEF_HOP));
				send_item(CmdPacket, clock_us,
					make_packet(link_sb.hop, link_sb.tx_id, 5'd7, 4'h8, DEF_ID_HI));
				send_item(CmdPacket, clock_us,
					make_packet(link_sb.hop, link_sb.tx_id, 5'd7, 4'h8, DEF_ID_LO));
				// first half while hunting only loads the code, second half locks
				send_item(CmdPacket, clock_us,
					make_packet(link_sb.hop, link_sb.tx_id, 5'h1F, 4'h0, DEF_NONE));
				send_item(CmdPacket, clock_us + 32'd100,
					make_packet(link_sb.hop, link_sb.tx_id, 5'h00, 4'h8, DEF_NONE));
				// sticks and failsafe for both halves, with the largest hop code
				send_item(CmdPacket, clock_us + 32'd200,
					make_packet(link_sb.hop, link_sb.tx_id, 5'h1F, 4'h0, DEF_NONE));
				send_item(CmdPacket, clock_us + 32'd300,
					make_packet(link_sb.hop, link_sb.tx_id, 5'h1E, 4'h8, DEF_NONE));
				send_item(CmdPacket, clock_us + 32'd400,
					make_packet(link_sb.hop, link_sb.tx_id, 5'h1F, 4'h4, DEF_NONE));
				send_item(CmdPacket, clock_us + 32'd500,
					make_packet(link_sb.hop, link_sb.tx_id, 5'h1F, 4'hC, DEF_NONE));
				// half a time range away is not passed, one less is
				send_item(CmdPoll, link_sb.deadline + 32'h8000_0000, '0);
				send_item(CmdPoll, link_sb.deadline + 32'h7FFF_FFFF, '0);
				// empty slots until the link drops back to hunting
				repeat (4)
					send_item(CmdPoll, link_sb.deadline + 32'd1, '0);
				send_item(CmdPoll, 32'd0, '0);
				send_item(CmdRestart, 32'hFFFF_FFFF, '1);
				clock_us = link_sb.deadline - 32'd1000;
			end

			// random traffic, mostly well-formed packets on the current hop
			items = 0;
			while (items < ItemsPerPhase) begin
				pick = $urandom_range(99);
				rnd = $urandom;
				code = rnd[4:0];
				nib = rnd[8:5];
				nib[2] = (rnd[10:9] == 2'd0);
				poll_cmd = (rnd[14:13] == 2'd0) ? CmdSpare : CmdPoll;
				raw = {$urandom, $urandom, $urandom, $urandom};
				noise_pkt = raw[119:0];
				if (link_sb.mode == LINK_IDLE) begin
					if (pick < 80) begin
						clock_us += rnd[31:20];
						send_item(CmdRestart, clock_us, noise_pkt);
					end else begin
						send_item(rnd[12:11], $urandom, noise_pkt);
					end
				end else if (pick < 40) begin
					clock_us += rnd[31:20];
					send_item(CmdPacket, clock_us,
						make_packet(link_sb.hop, link_sb.tx_id, code, nib, DEF_NONE));
				end else if (pick < 50) begin
					send_item(CmdPacket, clock_us,
						make_packet(link_sb.hop, link_sb.tx_id, code, nib,
							pkt_defect_e'($urandom_range(5, 1))));
				end else if (pick < 62) begin
					clock_us = link_sb.deadline + $urandom_range(200, 1);
					send_item(poll_cmd, clock_us, noise_pkt);
				end else if (pick < 67) begin
					// run of empty slots, long enough to lose sync when the limit is below 8
					burst = (link_sb.max_missed < 8) ? link_sb.max_missed + 2 : 3;
					repeat (burst) begin
						clock_us = link_sb.deadline + $urandom_range(50, 1);
						send_item(CmdPoll, clock_us, noise_pkt);
					end
				end else if (pick < 77) begin
					clock_us = link_sb.deadline - $urandom_range(200, 0);
					send_item(poll_cmd, clock_us, noise_pkt);
				end else if (pick < 85) begin
					clock_us += $urandom_range(10000, 0);
					send_item(poll_cmd, clock_us, noise_pkt);
				end else if (pick < 89) begin
					clock_us += rnd[31:20];
					send_item(CmdRestart, clock_us, noise_pkt);
				end else if (pick < 95) begin
					send_item(rnd[12:11], $urandom, noise_pkt);
				end else begin
					// around the signed wrap boundary of the deadline compare
					send_item(poll_cmd, link_sb.deadline + 32'h7FFF_FFFE + rnd[1:0], noise_pkt);
				end
				if (link_sb.mode != LINK_IDLE)
					items++;
			end

			// drain before the next register settings
			s_tvalid <= 1'b0;
			while (link_sb.awaited_reports.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end

		if (link_sb.errors == 0 && link_sb.awaited_reports.size() == 0)
			$display("hopping_rc_packet_receiver_top test passed");
		else
			$display("hopping_rc_packet_receiver_top test failed");
		$finish;
	end

endmodule
